@@ rtl/http_response_header_parser_macros.svh @@
// Assertion macros for the HTTP response header parser.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef HTTP_RESPONSE_HEADER_PARSER_MACROS_SVH
`define HTTP_RESPONSE_HEADER_PARSER_MACROS_SVH

// Same-cycle implication.
`define HRP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hrp: same-cycle check failed");

// Next-cycle implication.
`define HRP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hrp: next-cycle check failed");

`endif

@@ rtl/hrp_pkg.sv @@
// Shared types, constants and key tables of the HTTP response header parser.
// No dependencies.
package hrp_pkg;

    localparam int MAX_RESPONSE = 8192;
    localparam int TYPE_MAX     = 64;
    localparam int CNT_W        = $clog2(MAX_RESPONSE + 1);
    localparam int CAP_W        = $clog2(TYPE_MAX + 1);
    localparam int KEY_TYPE_LEN = 14;
    localparam int KEY_LEN_LEN  = 16;
    localparam int STATUS_LEN   = 7;
    localparam int COL_W        = 5;
    localparam int Q_DEPTH      = 4;
    localparam int QPTR_W       = $clog2(Q_DEPTH);
    localparam int QCNT_W       = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_LF = 8'd10;

    localparam logic [1:0] CLS_HEADER = 2'd0;
    localparam logic [1:0] CLS_TYPE   = 2'd1;
    localparam logic [1:0] CLS_BODY   = 2'd2;
    localparam logic [1:0] CLS_DROP   = 2'd3;

    localparam logic [1:0] ERR_OK         = 2'd0;
    localparam logic [1:0] ERR_NO_RESP    = 2'd1;
    localparam logic [1:0] ERR_BAD_HDR    = 2'd2;
    localparam logic [1:0] ERR_BAD_STATUS = 2'd3;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         byte_class;
        logic [7:0]         byte_out;
        logic               header_done;
        logic signed [15:0] status_raw;
        logic               status_valid;
        logic [31:0]        length_total;
        logic               length_known;
        logic               body_complete;
        logic [1:0]         error_code;
    } t_out_item;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] data_byte;
        logic       end_of_stream;
        logic       is_cr;
        logic       is_lf;
        logic       is_digit;
        logic [3:0] digit;
    } t_tok;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] level;
    } t_q_status;

    function automatic logic [7:0] status_key(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = "H";
            3'd1:    c = "T";
            3'd2:    c = "T";
            3'd3:    c = "P";
            3'd4:    c = "/";
            3'd5:    c = "1";
            3'd6:    c = ".";
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] type_key(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = "C";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "T";
            4'd9:    c = "y";
            4'd10:   c = "p";
            4'd11:   c = "e";
            4'd12:   c = ":";
            4'd13:   c = " ";
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] length_key(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = "C";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "L";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            4'd14:   c = ":";
            default: c = " ";
        endcase
        return c;
    endfunction

endpackage

@@ rtl/hrp_front.sv @@
// Front end: accepts input transactions and classifies each byte.
// Depends on hrp_pkg.
module hrp_front (
    input  logic            i_in_valid,
    input  hrp_pkg::t_in_item i_in,
    input  logic            i_q_full,
    output logic            o_in_ready,
    output logic            o_push,
    output hrp_pkg::t_tok   o_tok
);
    import hrp_pkg::*;

    logic [7:0] b;

    assign b          = i_in.data_byte;
    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_tok.has_byte      = i_in.has_byte;
        o_tok.data_byte     = b;
        o_tok.end_of_stream = i_in.end_of_stream;
        o_tok.is_cr         = (b == CH_CR);
        o_tok.is_lf         = (b == CH_LF);
        o_tok.is_digit      = (b >= "0") && (b <= "9");
        o_tok.digit         = b[3:0];
    end

endmodule

@@ rtl/hrp_queue.sv @@
// Short queue of classified bytes between the front and back ends.
// Depends on hrp_pkg.
module hrp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  hrp_pkg::t_tok     i_tok,
    input  logic              i_pop,
    output hrp_pkg::t_tok     o_tok,
    output hrp_pkg::t_q_status o_status
);
    import hrp_pkg::*;

    t_tok              r_mem [Q_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_level;
    logic              do_push;
    logic              do_pop;

    assign do_push = i_push && (r_level != QCNT_W'(Q_DEPTH));
    assign do_pop  = i_pop && (r_level != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_level <= r_level + 1'b1;
            end else if (do_pop && !do_push) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_tok;
        end
    end

    assign o_tok           = r_mem[r_rd_ptr];
    assign o_status.full   = (r_level == QCNT_W'(Q_DEPTH));
    assign o_status.empty  = (r_level == '0);
    assign o_status.level  = r_level;

endmodule

@@ rtl/hrp_back.sv @@
// Back end: parser state update per byte and registered result transaction.
// Depends on hrp_pkg.
module hrp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  hrp_pkg::t_tok     i_tok,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output hrp_pkg::t_out_item o_out
);
    import hrp_pkg::*;

    typedef enum logic [2:0] {
        TERM_NONE,
        TERM_CR,
        TERM_CRLF,
        TERM_CRLFCR,
        TERM_LF
    } t_term_e;

    logic [CNT_W-1:0]   r_byte_count, n_byte_count;
    t_term_e            r_term, n_term;
    logic [COL_W-1:0]   r_col, n_col;
    logic [1:0]         r_flags, n_flags;
    logic [CAP_W-1:0]   r_cap, n_cap;
    logic               r_digits, n_digits;
    logic [31:0]        r_len, n_len;
    logic               r_len_seen, n_len_seen;
    logic signed [15:0] r_status, n_status;
    logic               r_prefix_ok, n_prefix_ok;
    logic               r_hdr_end, n_hdr_end;
    logic [31:0]        r_body, n_body;
    logic               r_out_valid;
    t_out_item          r_out, n_out;

    logic [7:0]         b;
    logic signed [15:0] sdig;
    logic [1:0]         cls;
    logic               svalid;

    assign o_pop       = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign b           = i_tok.data_byte;
    assign sdig        = $signed({8'd0, b}) - 16'sd48;

    always_comb begin
        n_byte_count = r_byte_count;
        n_term       = r_term;
        n_col        = r_col;
        n_flags      = r_flags;
        n_cap        = r_cap;
        n_digits     = r_digits;
        n_len        = r_len;
        n_len_seen   = r_len_seen;
        n_status     = r_status;
        n_prefix_ok  = r_prefix_ok;
        n_hdr_end    = r_hdr_end;
        n_body       = r_body;
        cls          = CLS_HEADER;

        if (i_tok.has_byte) begin
            if (r_byte_count >= CNT_W'(MAX_RESPONSE)) begin
                cls = CLS_DROP;
            end else begin
                n_byte_count = r_byte_count + 1'b1;
                if (r_byte_count < CNT_W'(STATUS_LEN)
                    && b != status_key(r_byte_count[2:0])) begin
                    n_prefix_ok = 1'b0;
                end
                if (r_byte_count == CNT_W'(9)) begin
                    n_status = r_status + 16'(sdig * 16'sd100);
                end else if (r_byte_count == CNT_W'(10)) begin
                    n_status = r_status + 16'(sdig * 16'sd10);
                end else if (r_byte_count == CNT_W'(11)) begin
                    n_status = r_status + sdig;
                end

                if (r_hdr_end) begin
                    if (r_body != 32'hFFFF_FFFF) begin
                        n_body = r_body + 32'd1;
                    end
                    cls = CLS_BODY;
                end else begin
                    if (i_tok.is_cr) begin
                        n_term = (r_term == TERM_CRLF) ? TERM_CRLFCR : TERM_CR;
                    end else if (i_tok.is_lf) begin
                        if (r_term == TERM_CR) begin
                            n_term = TERM_CRLF;
                        end else if (r_term == TERM_CRLF || r_term == TERM_CRLFCR
                                     || r_term == TERM_LF) begin
                            n_hdr_end = 1'b1;
                            n_term    = TERM_NONE;
                        end else begin
                            n_term = TERM_LF;
                        end
                    end else begin
                        n_term = TERM_NONE;
                    end

                    if (i_tok.is_lf) begin
                        n_col    = '0;
                        n_flags  = 2'b11;
                        n_cap    = '0;
                        n_digits = 1'b0;
                    end else begin
                        if (r_cap != '0) begin
                            if (i_tok.is_cr || r_cap >= CAP_W'(TYPE_MAX)) begin
                                n_cap = '0;
                            end else begin
                                cls   = CLS_TYPE;
                                n_cap = r_cap + 1'b1;
                            end
                        end
                        if (r_digits) begin
                            if (i_tok.is_digit) begin
                                n_len = (r_len << 3) + (r_len << 1) + {28'd0, i_tok.digit};
                            end else begin
                                n_digits = 1'b0;
                            end
                        end
                        if (r_col < COL_W'(KEY_TYPE_LEN) && r_flags[0]) begin
                            if (b != type_key(r_col[3:0])) begin
                                n_flags[0] = 1'b0;
                            end else if (r_col == COL_W'(KEY_TYPE_LEN - 1)) begin
                                n_cap = CAP_W'(1);
                            end
                        end
                        if (r_col < COL_W'(KEY_LEN_LEN) && r_flags[1]) begin
                            if (b != length_key(r_col[3:0])) begin
                                n_flags[1] = 1'b0;
                            end else if (r_col == COL_W'(KEY_LEN_LEN - 1) && !r_len_seen) begin
                                n_len_seen = 1'b1;
                                n_digits   = 1'b1;
                                n_len      = '0;
                            end
                        end
                        n_col = (r_col != '1) ? r_col + 1'b1 : r_col;
                    end
                end
            end
        end

        svalid = n_prefix_ok && (n_byte_count >= CNT_W'(12));

        n_out.byte_class    = cls;
        n_out.byte_out      = i_tok.has_byte ? b : 8'd0;
        n_out.header_done   = n_hdr_end;
        n_out.status_raw    = n_status;
        n_out.status_valid  = svalid;
        n_out.length_total  = n_len;
        n_out.length_known  = n_len_seen;
        n_out.body_complete = n_hdr_end && n_len_seen && (n_body >= n_len);
        n_out.error_code    = ERR_OK;
        if (i_tok.end_of_stream) begin
            if (n_byte_count == '0) begin
                n_out.error_code = ERR_NO_RESP;
            end else if (!n_hdr_end) begin
                n_out.error_code = ERR_BAD_HDR;
            end else if (!svalid) begin
                n_out.error_code = ERR_BAD_STATUS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_pop && i_tok.end_of_stream)) begin
            r_byte_count <= '0;
            r_term       <= TERM_NONE;
            r_col        <= '0;
            r_flags      <= 2'b11;
            r_cap        <= '0;
            r_digits     <= 1'b0;
            r_len        <= '0;
            r_len_seen   <= 1'b0;
            r_status     <= '0;
            r_prefix_ok  <= 1'b1;
            r_hdr_end    <= 1'b0;
            r_body       <= '0;
        end else if (o_pop) begin
            r_byte_count <= n_byte_count;
            r_term       <= n_term;
            r_col        <= n_col;
            r_flags      <= n_flags;
            r_cap        <= n_cap;
            r_digits     <= n_digits;
            r_len        <= n_len;
            r_len_seen   <= n_len_seen;
            r_status     <= n_status;
            r_prefix_ok  <= n_prefix_ok;
            r_hdr_end    <= n_hdr_end;
            r_body       <= n_body;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

endmodule

@@ rtl/http_response_header_parser.sv @@
// HTTP response header parser: one byte per transaction, one result each.
// The accepted byte is written into the queue entry, from which the back end
// loads the result register; an output stall can hold the entry back.
// Throughput: one byte per cycle while the output accepts results, set by the
// state update in the back end; a four-entry queue absorbs output stalls. Reset:
// synchronous active-low i_rst_n clears parser state, queue and result valid;
// state also returns to reset after an end_of_stream result.
module http_response_header_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  hrp_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output hrp_pkg::t_out_item o_out
);
    import hrp_pkg::*;

`include "http_response_header_parser_macros.svh"

    logic      push;
    logic      pop;
    t_tok      front_tok;
    t_tok      q_tok;
    t_q_status q_stat;

    hrp_front u_front (
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .i_q_full   (q_stat.full),
        .o_in_ready (o_in_ready),
        .o_push     (push),
        .o_tok      (front_tok)
    );

    hrp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_tok    (front_tok),
        .i_pop    (pop),
        .o_tok    (q_tok),
        .o_status (q_stat)
    );

    hrp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (!q_stat.empty),
        .i_tok       (q_tok),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    `HRP_ASSERT_NOW(a_q_level, 1'b1, q_stat.level <= QCNT_W'(Q_DEPTH))
    `HRP_ASSERT_NOW(a_body_after_hdr, o_out_valid && o_out.byte_class == CLS_BODY, o_out.header_done)
    `HRP_ASSERT_NOW(a_complete, o_out_valid && o_out.body_complete, o_out.header_done && o_out.length_known)
    `HRP_ASSERT_NEXT(a_push_lands, push && !pop, !q_stat.empty)

endmodule
